// ----- sv/mmn_pkg.sv -----
// Shared types, constants and codes for the min/max normalizer.
`timescale 1ns / 1ps
package mmn_pkg;

  localparam int SAMPLE_BITS    = 32;
  localparam int FRACTION_BITS  = 16;
  localparam int VALUE_BITS     = FRACTION_BITS + 2;
  localparam int WIDE_BITS      = SAMPLE_BITS + 1;
  localparam int QUO_BITS       = FRACTION_BITS + 2;
  localparam int CNT_BITS       = $clog2(FRACTION_BITS + 2);
  localparam int STATUS_BITS    = 2;
  localparam int MODE_BITS      = 3;
  localparam int CFG_INDEX_BITS = 2;

  localparam logic signed [VALUE_BITS-1:0] ONE_Q       = {2'b01, {FRACTION_BITS{1'b0}}};
  localparam logic signed [VALUE_BITS-1:0] MINUS_ONE_Q = {2'b11, {FRACTION_BITS{1'b0}}};
  localparam logic signed [VALUE_BITS-1:0] ZERO_Q      = '0;

  localparam logic signed [SAMPLE_BITS-1:0] RANGE_HIGH_RESET =
    {{(SAMPLE_BITS-FRACTION_BITS-1){1'b0}}, 1'b1, {FRACTION_BITS{1'b0}}};

  typedef enum logic [MODE_BITS-1:0] {
    MODE_LIN_FIXED = 3'd0,
    MODE_LIN_AUTO  = 3'd1,
    MODE_BI_FIXED  = 3'd2,
    MODE_BI_AUTO   = 3'd3,
    MODE_UNI_FIXED = 3'd4,
    MODE_UNI_AUTO  = 3'd5
  } mode_t;

  typedef enum logic [STATUS_BITS-1:0] {
    STAT_OK       = 2'd0,
    STAT_ZERO_W   = 2'd1,
    STAT_NO_MEAS  = 2'd2
  } status_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_MODE       = 2'd0,
    REG_RANGE_LOW  = 2'd1,
    REG_RANGE_HIGH = 2'd2,
    REG_THRESHOLD  = 2'd3
  } reg_index_t;

  localparam logic KIND_MEASURE   = 1'b0;
  localparam logic KIND_NORMALIZE = 1'b1;

  typedef struct packed {
    mode_t                          mode;
    logic signed [SAMPLE_BITS-1:0]  range_low;
    logic signed [SAMPLE_BITS-1:0]  range_high;
    logic signed [SAMPLE_BITS-1:0]  fixed_threshold;
  } cfg_t;

  typedef struct packed {
    logic start;
    logic long_n;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic zero;
  } div_rsp_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PREP,
    S_DIV,
    S_OUT
  } top_state_t;

  typedef enum logic [2:0] {
    D_IDLE,
    D_NORM,
    D_RANGE,
    D_STEP,
    D_DONE
  } div_state_t;

endpackage

// ----- sv/mmn_in_if.sv -----
// Input sample channel: kind, restart flag and sample.
`timescale 1ns / 1ps
interface mmn_in_if;
  import mmn_pkg::*;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic                          restart;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output kind, output restart, output sample, input ready);
  modport sink   (input valid, input kind, input restart, input sample, output ready);
endinterface

// ----- sv/mmn_out_if.sv -----
// Result channel: normalized value and status.
`timescale 1ns / 1ps
interface mmn_out_if;
  import mmn_pkg::*;
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] value;
  logic [STATUS_BITS-1:0]       status;

  modport source (output valid, output value, output status, input ready);
  modport sink   (input valid, input value, input status, output ready);
endinterface

// ----- sv/mmn_cfg_if.sv -----
// Configuration write channel: register index and write data.
`timescale 1ns / 1ps
interface mmn_cfg_if;
  import mmn_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [CFG_INDEX_BITS-1:0] index;
  logic [SAMPLE_BITS-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- sv/mmn_cfg_regs.sv -----
// Configuration register file for the normalizer.
`timescale 1ns / 1ps
module mmn_cfg_regs (
  input  logic         clk,
  input  logic         rst,
  mmn_cfg_if.sink      cfg,
  output mmn_pkg::cfg_t regs
);
  import mmn_pkg::*;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.mode            <= MODE_LIN_FIXED;
      regs.range_low       <= '0;
      regs.range_high      <= RANGE_HIGH_RESET;
      regs.fixed_threshold <= '0;
    end else if (cfg.valid) begin
      unique case (reg_index_t'(cfg.index))
        REG_MODE:       regs.mode            <= mode_t'(cfg.data[MODE_BITS-1:0]);
        REG_RANGE_LOW:  regs.range_low       <= cfg.data;
        REG_RANGE_HIGH: regs.range_high      <= cfg.data;
        REG_THRESHOLD:  regs.fixed_threshold <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule

// ----- sv/mmn_divider.sv -----
// Restoring radix-2 divider giving a clipped fractional ratio num/den.
`timescale 1ns / 1ps
module mmn_divider (
  input  logic                                   clk,
  input  logic                                   rst,
  input  mmn_pkg::div_req_t                      req,
  input  logic signed [mmn_pkg::WIDE_BITS-1:0]   num,
  input  logic signed [mmn_pkg::WIDE_BITS-1:0]   den,
  output mmn_pkg::div_rsp_t                      rsp,
  output logic [mmn_pkg::QUO_BITS-1:0]           quo
);
  import mmn_pkg::*;

  div_state_t                  state;
  div_state_t                  state_next;
  logic signed [WIDE_BITS-1:0] a_reg;
  logic signed [WIDE_BITS-1:0] d_reg;
  logic [SAMPLE_BITS-1:0]      rem;
  logic [SAMPLE_BITS-1:0]      dvs;
  logic [CNT_BITS-1:0]         cnt;
  logic                        long_n;
  logic                        zero;
  logic [CNT_BITS-1:0]         steps;
  logic [SAMPLE_BITS:0]        shifted;
  logic                        fits;

  assign steps   = long_n ? CNT_BITS'(FRACTION_BITS + 1) : CNT_BITS'(FRACTION_BITS);
  assign shifted = {rem, 1'b0};
  assign fits    = shifted >= {1'b0, dvs};

  always_comb begin
    state_next = state;
    unique case (state)
      D_IDLE:  if (req.start) state_next = D_NORM;
      D_NORM:  state_next = (d_reg == '0) ? D_DONE : D_RANGE;
      D_RANGE: begin
        if (a_reg < 0 || a_reg >= d_reg) state_next = D_DONE;
        else                             state_next = D_STEP;
      end
      D_STEP:  if (cnt == CNT_BITS'(1)) state_next = D_DONE;
      D_DONE:  state_next = D_IDLE;
      default: state_next = D_IDLE;
    endcase
  end

  always_comb begin
    rsp.done = (state == D_DONE);
    rsp.zero = zero;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= D_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    unique case (state)
      D_IDLE: begin
        a_reg  <= num;
        d_reg  <= den;
        long_n <= req.long_n;
        zero   <= 1'b0;
      end
      D_NORM: begin
        // flip both signs so the divisor is positive
        if (d_reg == '0) begin
          zero <= 1'b1;
          quo  <= '0;
        end else if (d_reg < 0) begin
          a_reg <= -a_reg;
          d_reg <= -d_reg;
        end
      end
      D_RANGE: begin
        if (a_reg < 0) begin
          quo <= '0;
        end else if (a_reg >= d_reg) begin
          quo <= QUO_BITS'(1) << steps;
        end else begin
          rem <= a_reg[SAMPLE_BITS-1:0];
          dvs <= d_reg[SAMPLE_BITS-1:0];
          quo <= '0;
          cnt <= steps;
        end
      end
      D_STEP: begin
        if (fits) rem <= SAMPLE_BITS'(shifted - {1'b0, dvs});
        else      rem <= shifted[SAMPLE_BITS-1:0];
        quo <= {quo[QUO_BITS-2:0], fits};
        cnt <= cnt - CNT_BITS'(1);
      end
      default: ;
    endcase
  end

endmodule

// ----- sv/minmax_normalizer_unit.sv -----
// Top level of the min/max normalizer: sequencer, min/max tracking and result register.
//
//   channel   role   fields                      accepted when
//   cfg       sink   index[1:0], data[31:0]      cfg.valid && cfg.ready
//   samples   sink   kind, restart, sample[31:0] samples.valid && samples.ready
//   results   source value[17:0], status[1:0]  results.valid && results.ready
//
// A measure word is folded into min/max at acceptance.
// Threshold modes, unused modes and auto modes with nothing measured skip the divider.
// Linear modes run the shared radix-2 divider for 16 or 17 quotient bits;
// a zero-width range ends it after the sign step and a ratio outside [0, 1) after the range check.
// Reset is synchronous and active high; it clears min/max and the configuration registers.
// A stall on results holds the finished word; the next sample is taken once it is loaded.
`timescale 1ns / 1ps
module minmax_normalizer_unit (
  input  logic      clk,
  input  logic      rst,
  mmn_cfg_if.sink   cfg,
  mmn_in_if.sink    samples,
  mmn_out_if.source results
);
  import mmn_pkg::*;

  cfg_t                          regs;
  top_state_t                    state;
  top_state_t                    state_next;
  logic signed [SAMPLE_BITS-1:0] min_seen;
  logic signed [SAMPLE_BITS-1:0] max_seen;
  logic                          have_sample;
  logic signed [SAMPLE_BITS-1:0] item_x;
  logic signed [VALUE_BITS-1:0]  res_value;
  logic [STATUS_BITS-1:0]        res_status;
  logic                          out_valid;
  logic signed [VALUE_BITS-1:0]  out_value;
  logic [STATUS_BITS-1:0]        out_status;

  div_req_t                      div_req;
  div_rsp_t                      div_rsp;
  logic signed [WIDE_BITS-1:0]   div_num;
  logic signed [WIDE_BITS-1:0]   div_den;
  logic [QUO_BITS-1:0]           div_quo;

  logic                          in_fire;
  logic                          out_free;
  logic                          is_linear;
  logic signed [WIDE_BITS-1:0]   mid_sum;
  logic signed [SAMPLE_BITS-1:0] auto_thr;
  logic signed [SAMPLE_BITS-1:0] thr;
  logic                          below;

  mmn_cfg_regs u_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  mmn_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .num (div_num),
    .den (div_den),
    .rsp (div_rsp),
    .quo (div_quo)
  );

  assign in_fire  = samples.valid && samples.ready;
  assign out_free = !out_valid || results.ready;

  // floor((min+max)/2) is an arithmetic shift of the widened sum
  assign mid_sum  = WIDE_BITS'(min_seen) + WIDE_BITS'(max_seen);
  assign auto_thr = mid_sum[WIDE_BITS-1:1];
  assign thr      = (regs.mode == MODE_BI_FIXED || regs.mode == MODE_UNI_FIXED)
                    ? regs.fixed_threshold : auto_thr;
  assign below    = item_x < thr;

  assign is_linear = (regs.mode == MODE_LIN_FIXED) ||
                     (regs.mode == MODE_LIN_AUTO && have_sample);

  always_comb begin
    if (regs.mode == MODE_LIN_FIXED) begin
      div_num = WIDE_BITS'(item_x) - WIDE_BITS'(regs.range_low);
      div_den = WIDE_BITS'(regs.range_high) - WIDE_BITS'(regs.range_low);
    end else begin
      div_num = WIDE_BITS'(item_x) - WIDE_BITS'(min_seen);
      div_den = WIDE_BITS'(max_seen) - WIDE_BITS'(min_seen);
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_fire && samples.kind == KIND_NORMALIZE) state_next = S_PREP;
      S_PREP: state_next = is_linear ? S_DIV : S_OUT;
      S_DIV:  if (div_rsp.done) state_next = S_OUT;
      S_OUT:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    samples.ready  = (state == S_IDLE);
    div_req.start  = (state == S_PREP) && is_linear;
    div_req.long_n = (regs.mode == MODE_LIN_FIXED);
  end

  assign results.valid  = out_valid;
  assign results.value  = out_value;
  assign results.status = out_status;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // min/max tracking on measure words
  always_ff @(posedge clk) begin
    if (rst) begin
      min_seen    <= '0;
      max_seen    <= '0;
      have_sample <= 1'b0;
    end else if (in_fire && samples.kind == KIND_MEASURE) begin
      if (!have_sample || samples.restart) begin
        min_seen <= samples.sample;
        max_seen <= samples.sample;
      end else begin
        if (samples.sample < min_seen) min_seen <= samples.sample;
        if (samples.sample > max_seen) max_seen <= samples.sample;
      end
      have_sample <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) item_x <= samples.sample;
  end

  always_ff @(posedge clk) begin
    if (state == S_PREP) begin
      res_status <= STAT_OK;
      res_value  <= ZERO_Q;
      unique case (regs.mode) inside
        MODE_LIN_AUTO: begin
          if (!have_sample) res_status <= STAT_NO_MEAS;
        end
        MODE_BI_FIXED, MODE_BI_AUTO: begin
          if (regs.mode == MODE_BI_AUTO && !have_sample) res_status <= STAT_NO_MEAS;
          else res_value <= below ? MINUS_ONE_Q : ONE_Q;
        end
        MODE_UNI_FIXED, MODE_UNI_AUTO: begin
          if (regs.mode == MODE_UNI_AUTO && !have_sample) res_status <= STAT_NO_MEAS;
          else res_value <= below ? ZERO_Q : ONE_Q;
        end
        default: ;
      endcase
    end else if (state == S_DIV && div_rsp.done) begin
      if (div_rsp.zero) begin
        res_status <= STAT_ZERO_W;
        res_value  <= ZERO_Q;
      end else if (regs.mode == MODE_LIN_FIXED) begin
        // map [0,2] to [-1,1]
        res_status <= STAT_OK;
        res_value  <= VALUE_BITS'(div_quo) - ONE_Q;
      end else begin
        res_status <= STAT_OK;
        res_value  <= VALUE_BITS'(div_quo);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      out_value  <= res_value;
      out_status <= res_status;
    end
  end

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the min/max normalizer.
`timescale 1ns / 1ps
module tb;
  import mmn_pkg::*;

  localparam int SETTLE_CYCLES  = 30;    // longest divide plus margin
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int RAND_ITEMS     = 650;
  localparam int DIR_ROWS       = 41;
  localparam int REPORT_MAX     = 10;

  localparam logic [MODE_BITS-1:0] MODE_RSVD6 = 3'd6;
  localparam logic [MODE_BITS-1:0] MODE_RSVD7 = 3'd7;

  typedef enum logic {STEP_CFG, STEP_ITEM} step_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    status_t               status;
  } norm_res_t;

  typedef struct packed {
    step_t                  act;
    reg_index_t             idx;
    logic                   kind;
    logic                   restart;
    logic [SAMPLE_BITS-1:0] data;
    logic                   typed;
    norm_res_t              want;
  } drow_t;

  logic clk;
  logic rst;

  mmn_cfg_if cfg_bus ();
  mmn_in_if  smp_bus ();
  mmn_out_if res_bus ();

  minmax_normalizer_unit u_dut (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_bus),
    .samples (smp_bus),
    .results (res_bus)
  );

  // shadow of the register file and of the min/max tracker
  logic [MODE_BITS-1:0]          sh_mode;
  logic signed [SAMPLE_BITS-1:0] sh_low;
  logic signed [SAMPLE_BITS-1:0] sh_high;
  logic signed [SAMPLE_BITS-1:0] sh_thr;
  logic signed [SAMPLE_BITS-1:0] seen_min;
  logic signed [SAMPLE_BITS-1:0] seen_max;
  bit                            seen_any;

  norm_res_t norm_due [$];
  int        miss_cnt;
  int        idle_cycles;
  bit        in_cfg;
  drow_t     dir_tab [DIR_ROWS];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // num/den clipped to [0, 1] with nbits fraction bits, truncated
  function automatic longint clip_ratio(input longint num, input longint den, input int nbits,
                                        output bit flat);
    flat = 1'b0;
    if (den == 0) begin
      flat = 1'b1;
      return 0;
    end
    if (den < 0) begin
      num = -num;
      den = -den;
    end
    if (num < 0) return 0;
    if (num >= den) return longint'(1) << nbits;
    return (num << nbits) / den;
  endfunction

  function automatic norm_res_t norm_predict(input logic signed [SAMPLE_BITS-1:0] x);
    norm_res_t res;
    longint    q;
    longint    xs;
    longint    mid;
    bit        flat;
    res.value  = ZERO_Q;
    res.status = STAT_OK;
    xs = x;
    mid = (longint'(seen_min) + longint'(seen_max)) >>> 1;
    case (sh_mode) inside
      MODE_LIN_FIXED: begin
        q = clip_ratio(xs - sh_low, longint'(sh_high) - longint'(sh_low),
                       FRACTION_BITS + 1, flat);
        if (flat) res.status = STAT_ZERO_W;
        else res.value = q[VALUE_BITS-1:0] - ONE_Q;
      end
      MODE_LIN_AUTO: begin
        if (!seen_any) begin
          res.status = STAT_NO_MEAS;
        end else begin
          q = clip_ratio(xs - seen_min, longint'(seen_max) - longint'(seen_min),
                         FRACTION_BITS, flat);
          if (flat) res.status = STAT_ZERO_W;
          else res.value = q[VALUE_BITS-1:0];
        end
      end
      MODE_BI_FIXED, MODE_UNI_FIXED: begin
        if (x < sh_thr) res.value = (sh_mode == MODE_BI_FIXED) ? MINUS_ONE_Q : ZERO_Q;
        else res.value = ONE_Q;
      end
      MODE_BI_AUTO, MODE_UNI_AUTO: begin
        if (!seen_any) res.status = STAT_NO_MEAS;
        else if (xs < mid) res.value = (sh_mode == MODE_BI_AUTO) ? MINUS_ONE_Q : ZERO_Q;
        else res.value = ONE_Q;
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic int pick_gap(input bit tight);
    int r;
    r = $urandom_range(0, 99);
    if (tight || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // uniform value between two bounds, in either order
  function automatic longint spread(input longint a, input longint b);
    longint    lo;
    longint    hi;
    bit [63:0] rnd;
    lo  = (a < b) ? a : b;
    hi  = (a < b) ? b : a;
    rnd = {$urandom, $urandom};
    return lo + longint'(rnd % 64'(hi - lo + 1));
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] draw_sample(input longint a, input longint b);
    int     r;
    int     off;
    longint s;
    r = $urandom_range(0, 9);
    if (r < 2) return $urandom;
    if (r == 2) begin
      case ($urandom_range(0, 4))
        0: return 32'h8000_0000;
        1: return 32'h7FFF_FFFF;
        2: return 32'h0000_0000;
        3: return 32'hFFFF_FFFF;
        default: return 32'h0001_0000;
      endcase
    end
    s = spread(a, b);
    if ($urandom_range(0, 3) == 0) begin
      off = $urandom_range(0, 6);
      s = s + off - 3;
    end
    return s[SAMPLE_BITS-1:0];
  endfunction

  function automatic drow_t cfg_row(input reg_index_t idx, input logic [SAMPLE_BITS-1:0] data);
    return '{STEP_CFG, idx, KIND_MEASURE, 1'b0, data, 1'b0, '{ZERO_Q, STAT_OK}};
  endfunction

  function automatic drow_t item_row(input logic kind, input logic restart,
                                     input logic [SAMPLE_BITS-1:0] sample, input logic typed,
                                     input logic [VALUE_BITS-1:0] value, input status_t status);
    return '{STEP_ITEM, REG_MODE, kind, restart, sample, typed, '{value, status}};
  endfunction

  task automatic fold_sample(input logic restart, input logic signed [SAMPLE_BITS-1:0] x);
    if (!seen_any || restart) begin
      seen_min = x;
      seen_max = x;
    end else begin
      if (x < seen_min) seen_min = x;
      if (x > seen_max) seen_max = x;
    end
    seen_any = 1'b1;
  endtask

  task automatic push_word(input logic kind, input logic restart,
                           input logic [SAMPLE_BITS-1:0] sample, input bit typed,
                           input norm_res_t given, input bit tight);
    int gap;
    gap = pick_gap(tight);
    if (gap > 0) begin
      @(negedge clk);
      smp_bus.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    smp_bus.valid   = 1'b1;
    smp_bus.kind    = kind;
    smp_bus.restart = restart;
    smp_bus.sample  = sample;
    do @(posedge clk); while (!(smp_bus.valid && smp_bus.ready));
    if (kind == KIND_MEASURE) fold_sample(restart, sample);
    else norm_due.push_back(typed ? given : norm_predict(sample));
  endtask

  // hold off input, then let every result and any trailing measure word drain
  task automatic quiesce();
    @(negedge clk);
    smp_bus.valid = 1'b0;
    while (norm_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [SAMPLE_BITS-1:0] data);
    @(negedge clk);
    cfg_bus.valid = 1'b1;
    cfg_bus.index = idx;
    cfg_bus.data  = data;
    do @(posedge clk); while (!(cfg_bus.valid && cfg_bus.ready));
    case (idx)
      REG_MODE:       sh_mode = data[MODE_BITS-1:0];
      REG_RANGE_LOW:  sh_low  = data;
      REG_RANGE_HIGH: sh_high = data;
      REG_THRESHOLD:  sh_thr  = data;
      default: ;
    endcase
  endtask

  task automatic close_cfg();
    @(negedge clk);
    cfg_bus.valid = 1'b0;
  endtask

  task automatic random_setup();
    logic [SAMPLE_BITS-1:0] lo;
    logic [SAMPLE_BITS-1:0] hi;
    logic [SAMPLE_BITS-1:0] thr;
    int                     r;
    r = $urandom_range(0, 19);
    if (r < 18) write_reg(REG_MODE, 32'(r % 6));
    else if (r == 18) write_reg(REG_MODE, 32'(MODE_RSVD6));
    else write_reg(REG_MODE, 32'(MODE_RSVD7));
    if ($urandom_range(0, 1)) begin
      case ($urandom_range(0, 5))
        0: begin lo = $urandom; hi = lo + (32'd1 << $urandom_range(0, 24)); end
        1: begin lo = $urandom; hi = $urandom; end
        2: begin lo = 32'h8000_0000; hi = 32'h7FFF_FFFF; end
        3: begin lo = 32'h7FFF_FFFF; hi = 32'h8000_0000; end
        4: begin lo = $urandom; hi = lo; end
        default: begin
          lo = 32'($urandom_range(0, 1 << 20)) - 32'(1 << 19);
          hi = lo + 32'($urandom_range(1, 1 << 18));
        end
      endcase
      write_reg(REG_RANGE_LOW, lo);
      write_reg(REG_RANGE_HIGH, hi);
    end
    if ($urandom_range(0, 1)) begin
      case ($urandom_range(0, 3))
        0: thr = $urandom;
        1: thr = 32'h8000_0000;
        2: thr = 32'h7FFF_FFFF;
        default: thr = 32'($urandom_range(0, 1 << 18)) - 32'(1 << 17);
      endcase
      write_reg(REG_THRESHOLD, thr);
    end
  endtask

  // result side: random ready runs, long stalls now and then
  initial begin : sink_pace
    int run;
    res_bus.ready = 1'b0;
    forever begin
      if ($urandom_range(0, 1)) begin
        res_bus.ready = 1'b1;
        run = $urandom_range(1, 40);
      end else begin
        res_bus.ready = 1'b0;
        run = 1 + pick_gap(1'b0);
      end
      repeat (run) @(negedge clk);
    end
  end

  always @(posedge clk) begin : res_check
    norm_res_t want;
    if (!rst && res_bus.valid && res_bus.ready) begin
      if (norm_due.size() == 0) begin
        miss_cnt++;
        if (miss_cnt <= REPORT_MAX)
          $display("unexpected result word: value=%0d status=%0d",
                   $signed(res_bus.value), res_bus.status);
      end else begin
        want = norm_due.pop_front();
        if (res_bus.value !== want.value || res_bus.status !== want.status) begin
          miss_cnt++;
          if (miss_cnt <= REPORT_MAX)
            $display("result mismatch: expected value=%0d status=%0d, got value=%0d status=%0d",
                     $signed(want.value), want.status, $signed(res_bus.value), res_bus.status);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (smp_bus.valid && smp_bus.ready) || (res_bus.valid && res_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("minmax_normalizer_unit verification failed");
        $finish;
      end
    end
  end

  initial begin : stim
    int     sent;
    int     n;
    bit     tight;
    logic   kind;
    longint c_lo;
    longint c_hi;
    longint b_lo;
    longint b_hi;
    longint mid;

    rst             = 1'b1;
    smp_bus.valid   = 1'b0;
    smp_bus.kind    = KIND_MEASURE;
    smp_bus.restart = 1'b0;
    smp_bus.sample  = '0;
    cfg_bus.valid   = 1'b0;
    cfg_bus.index   = REG_MODE;
    cfg_bus.data    = '0;
    sh_mode         = MODE_LIN_FIXED;
    sh_low          = '0;
    sh_high         = RANGE_HIGH_RESET;
    sh_thr          = '0;
    seen_min        = '0;
    seen_max        = '0;
    seen_any        = 1'b0;
    miss_cnt        = 0;
    idle_cycles     = 0;
    in_cfg          = 1'b0;
    sent            = 0;

    dir_tab = '{
      // reset range [0, 1.0]: ends, saturation, midpoint, one LSB
      item_row(KIND_NORMALIZE, 1'b0, 32'h0000_0000, 1'b1, MINUS_ONE_Q, STAT_OK),
      item_row(KIND_NORMALIZE, 1'b0, 32'h0001_0000, 1'b1, ONE_Q, STAT_OK),
      item_row(KIND_NORMALIZE, 1'b0, 32'h8000_0000, 1'b1, MINUS_ONE_Q, STAT_OK),
      item_row(KIND_NORMALIZE, 1'b0, 32'h7FFF_FFFF, 1'b1, ONE_Q, STAT_OK),
      item_row(KIND_NORMALIZE, 1'b1, 32'h0000_8000, 1'b1, ZERO_Q, STAT_OK),
      item_row(KIND_NORMALIZE, 1'b0, 32'h0000_0001, 1'b0, ZERO_Q, STAT_OK),
      // auto modes with nothing measured
      cfg_row(REG_MODE, 32'(MODE_LIN_AUTO)),
      item_row(KIND_NORMALIZE, 1'b0, 32'h1234_5678, 1'b1, ZERO_Q, STAT_NO_MEAS),
      cfg_row(REG_MODE, 32'(MODE_BI_AUTO)),
      item_row(KIND_NORMALIZE, 1'b0, 32'hFFFF_FFFF, 1'b1, ZERO_Q, STAT_NO_MEAS),
      cfg_row(REG_MODE, 32'(MODE_UNI_AUTO)),
      item_row(KIND_NORMALIZE, 1'b0, 32'h0000_0000, 1'b1, ZERO_Q, STAT_NO_MEAS),
      // full-scale min/max; midpoint floors to -1
      item_row(KIND_MEASURE, 1'b0, 32'h8000_0000, 1'b0, ZERO_Q, STAT_OK),
      item_row(KIND_MEASURE, 1'b0, 32'h7FFF_FFFF, 1'b0, ZERO_Q, STAT_OK),
      item_row(KIND_NORMALIZE, 1'b0, 32'hFFFF_FFFE, 1'b1, ZERO_Q, STAT_OK),
      item_row(KIND_NORMALIZE, 1'b0, 32'hFFFF_FFFF, 1'b1, ONE_Q, STAT_OK),
      cfg_row(REG_MODE, 32'(MODE_BI_AUTO)),
      item_row(KIND_NORMALIZE, 1'b0, 32'hFFFF_FFFE, 1'b1, MINUS_ONE_Q, STAT_OK),
      cfg_row(REG_MODE, 32'(MODE_LIN_AUTO)),
      item_row(KIND_NORMALIZE, 1'b0, 32'h0000_0000, 1'b0, ZERO_Q, STAT_OK),
      item_row(KIND_NORMALIZE, 1'b0, 32'h7FFF_FFFF, 1'b1, ONE_Q, STAT_OK),
      // single measured point: zero width
      item_row(KIND_MEASURE, 1'b1, 32'h0003_0000, 1'b0, ZERO_Q, STAT_OK),
      item_row(KIND_NORMALIZE, 1'b0, 32'h0003_0000, 1'b1, ZERO_Q, STAT_ZERO_W),
      // fixed range: zero width, inverted, full scale
      cfg_row(REG_MODE, 32'(MODE_LIN_FIXED)),
      cfg_row(REG_RANGE_LOW, 32'h0001_0000),
      item_row(KIND_NORMALIZE, 1'b0, 32'h0002_0000, 1'b1, ZERO_Q, STAT_ZERO_W),
      cfg_row(REG_RANGE_HIGH, 32'h0000_0000),
      item_row(KIND_NORMALIZE, 1'b0, 32'h0000_4000, 1'b0, ZERO_Q, STAT_OK),
      cfg_row(REG_RANGE_LOW, 32'h8000_0000),
      cfg_row(REG_RANGE_HIGH, 32'h7FFF_FFFF),
      item_row(KIND_NORMALIZE, 1'b0, 32'h0000_0000, 1'b0, ZERO_Q, STAT_OK),
      // fixed thresholds at the extremes
      cfg_row(REG_MODE, 32'(MODE_BI_FIXED)),
      cfg_row(REG_THRESHOLD, 32'h8000_0000),
      item_row(KIND_NORMALIZE, 1'b0, 32'h8000_0000, 1'b1, ONE_Q, STAT_OK),
      cfg_row(REG_MODE, 32'(MODE_UNI_FIXED)),
      cfg_row(REG_THRESHOLD, 32'h7FFF_FFFF),
      item_row(KIND_NORMALIZE, 1'b0, 32'h7FFF_FFFE, 1'b1, ZERO_Q, STAT_OK),
      // unused mode codes
      cfg_row(REG_MODE, 32'(MODE_RSVD6)),
      item_row(KIND_NORMALIZE, 1'b0, 32'h7FFF_FFFF, 1'b1, ZERO_Q, STAT_OK),
      cfg_row(REG_MODE, 32'(MODE_RSVD7)),
      item_row(KIND_NORMALIZE, 1'b0, 32'h8000_0000, 1'b1, ZERO_Q, STAT_OK)
    };

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].act == STEP_CFG) begin
        if (!in_cfg) quiesce();
        in_cfg = 1'b1;
        write_reg(dir_tab[i].idx, dir_tab[i].data);
      end else begin
        if (in_cfg) close_cfg();
        in_cfg = 1'b0;
        push_word(dir_tab[i].kind, dir_tab[i].restart, dir_tab[i].data, dir_tab[i].typed,
                  dir_tab[i].want, 1'b0);
      end
    end

    while (sent < RAND_ITEMS) begin
      quiesce();
      random_setup();
      close_cfg();
      tight = ($urandom_range(0, 3) == 0);
      n     = $urandom_range(15, 50);
      c_lo  = longint'($signed($urandom));
      c_hi  = c_lo + (longint'(1) << $urandom_range(0, 31));
      // auto modes mostly start from a fresh measurement
      if (sh_mode inside {MODE_LIN_AUTO, MODE_BI_AUTO, MODE_UNI_AUTO} &&
          $urandom_range(0, 3) != 0)
        push_word(KIND_MEASURE, 1'b1, draw_sample(c_lo, c_hi), 1'b0, '0, tight);
      for (int k = 0; k < n; k++) begin
        kind = ($urandom_range(0, 9) < 3) ? KIND_MEASURE : KIND_NORMALIZE;
        b_lo = c_lo;
        b_hi = c_hi;
        mid  = (longint'(seen_min) + longint'(seen_max)) >>> 1;
        if (kind == KIND_NORMALIZE) begin
          case (sh_mode) inside
            MODE_LIN_FIXED: begin b_lo = sh_low; b_hi = sh_high; end
            MODE_BI_FIXED, MODE_UNI_FIXED: begin b_lo = sh_thr - 8; b_hi = sh_thr + 8; end
            default: begin
              if (seen_any) begin
                if (sh_mode != MODE_LIN_AUTO && $urandom_range(0, 1)) begin
                  b_lo = mid - 8;
                  b_hi = mid + 8;
                end else begin
                  b_lo = seen_min;
                  b_hi = seen_max;
                end
              end
            end
          endcase
        end
        push_word(kind, ($urandom_range(0, 9) == 0), draw_sample(b_lo, b_hi), 1'b0, '0,
                  tight);
      end
      sent += n;
    end

    @(negedge clk);
    smp_bus.valid = 1'b0;
    while (norm_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    miss_cnt += norm_due.size();
    if (miss_cnt == 0) begin
      $display("minmax_normalizer_unit verification clean");
    end else begin
      $display("minmax_normalizer_unit verification failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/mmn_pkg.sv
sv/mmn_in_if.sv
sv/mmn_out_if.sv
sv/mmn_cfg_if.sv
sv/mmn_cfg_regs.sv
sv/mmn_divider.sv
sv/minmax_normalizer_unit.sv
tb/tb.sv
